### rtl/core/pw565_pkg.sv
// ============================================================================
// pw565_pkg
// Shared types, codes and pixel conversion functions for the RGB565 packer.
// ============================================================================
package pw565_pkg;

    // Pixel format codes held in the format register
    localparam logic [2:0] FMT_PASS   = 3'd0;
    localparam logic [2:0] FMT_SWAP16 = 3'd1;
    localparam logic [2:0] FMT_RGB332 = 3'd2;
    localparam logic [2:0] FMT_GRAY8  = 3'd3;
    localparam logic [2:0] FMT_GRAY4  = 3'd4;
    localparam logic [2:0] FMT_CLUT   = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_FORMAT = 3'd0;
    localparam logic [2:0] REG_PAL_0  = 3'd1;
    localparam logic [2:0] REG_PAL_1  = 3'd2;
    localparam logic [2:0] REG_PAL_2  = 3'd3;
    localparam logic [2:0] REG_PAL_3  = 3'd4;

    // Stream word layout
    localparam int unsigned TDATA_W   = 40;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned COUNT_W   = 3;
    localparam logic [2:0]  MAX_BYTES = 3'd4;

    typedef logic [15:0] t_pixel;

    // RGB332 byte to RGB565 by bit replication
    function automatic t_pixel rgb332_to_565(input logic [7:0] v);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = {v[7:5], v[7:6]};
        g6 = {v[4:2], v[4:2]};
        b5 = {v[1:0], v[1:0], v[1]};
        return {r5, g6, b5};
    endfunction

    // 8-bit gray to RGB565
    function automatic t_pixel gray8_to_565(input logic [7:0] v);
        return {v[7:3], v[7:2], v[7:3]};
    endfunction

    // 4-bit gray to RGB565
    function automatic t_pixel gray4_to_565(input logic [3:0] nib);
        logic [5:0] g6;
        g6 = {nib, nib[3:2]};
        return {g6[5:1], g6, g6[5:1]};
    endfunction

endpackage

### rtl/core/pixel_to_rgb565_word_packer_top.sv
// ============================================================================
// pixel_to_rgb565_word_packer_top
// Converts source words to RGB565 display words, one result word a cycle while the output is not stalled.
// ============================================================================
// Usage:
//   Slave stream: tdata[31:0] source word (first byte in 7:0), tdata[34:32]
//   count of valid bytes. A word with count zero is consumed and makes no
//   output; counts above four act as four.
//   Master stream: tdata[31:0] packed word, tdata[34:32] bytes to send,
//   tlast marks the last output word of an input word.
//   Config channel: index 0 format, 1..4 colour table quarters. Write only
//   while the block is idle; cfg ready is always high.
// Timing:
//   An input word sits in the input register and produces one output word
//   per cycle into the output register while the output is not stalled:
//   one word in pass/swap16 mode, up to two in rgb332/gray8 and up to four
//   in gray4/colour table mode. The input register is the limit: the next
//   word is taken in the cycle its last output word moves to the output register.
//   A stalled output holds its word; the input stalls once both registers
//   are full. Reset empties both registers and clears all config registers.
// ============================================================================
module pixel_to_rgb565_word_packer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [31:0] source_word, [34:32] valid_bytes
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] packed_word, [34:32] send_bytes
    output logic        o_m_axis_tlast,   // run_end
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // config registers
    logic [2:0]  r_format;
    logic [63:0] r_pal [4];

    // input register
    logic        r_in_valid;
    logic [31:0] r_word;
    logic [2:0]  r_nbytes;
    logic [1:0]  r_idx;
    logic [1:0]  r_last_idx;

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic [2:0]  r_out_send;
    logic        r_out_last;

    logic        advance;
    logic        is_last;
    logic        load;
    logic [2:0]  in_count;
    logic [2:0]  in_nbytes;
    logic [2:0]  in_last_idx;
    logic [31:0] n_out_word;
    logic [2:0]  n_out_send;

    assign o_cfg_ready = 1'b1;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= pw565_pkg::FMT_PASS;
            r_pal[0] <= '0;
            r_pal[1] <= '0;
            r_pal[2] <= '0;
            r_pal[3] <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pw565_pkg::REG_FORMAT: r_format <= i_cfg_data[2:0];
                pw565_pkg::REG_PAL_0:  r_pal[0] <= i_cfg_data;
                pw565_pkg::REG_PAL_1:  r_pal[1] <= i_cfg_data;
                pw565_pkg::REG_PAL_2:  r_pal[2] <= i_cfg_data;
                pw565_pkg::REG_PAL_3:  r_pal[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake control
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign is_last         = (r_idx == r_last_idx);
    assign o_s_axis_tready = !r_in_valid || (advance && is_last);
    assign in_count        = i_s_axis_tdata[34:32];
    assign load            = i_s_axis_tvalid && o_s_axis_tready && (in_count != 3'd0);

    // clamp count and work out how many output words the item makes
    always_comb begin
        in_nbytes = (in_count > pw565_pkg::MAX_BYTES) ? pw565_pkg::MAX_BYTES : in_count;
        unique case (r_format)
            pw565_pkg::FMT_RGB332,
            pw565_pkg::FMT_GRAY8: in_last_idx = (in_nbytes - 3'd1) >> 1;
            pw565_pkg::FMT_GRAY4,
            pw565_pkg::FMT_CLUT:  in_last_idx = in_nbytes - 3'd1;
            default:              in_last_idx = 3'd0;
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_idx      <= 2'd0;
        end else if (load) begin
            r_in_valid <= 1'b1;
            r_idx      <= 2'd0;
        end else if (advance) begin
            if (is_last) begin
                r_in_valid <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word     <= i_s_axis_tdata[31:0];
            r_nbytes   <= in_nbytes;
            r_last_idx <= in_last_idx[1:0];
        end
    end

    // result word for the current index
    logic [7:0]  pair_a;
    logic [7:0]  pair_b;
    logic        pair_half;
    logic [7:0]  nib_byte;
    logic [1:0]  pair_sel;
    logic [15:0] pix_a;
    logic [15:0] pix_b;

    always_comb begin
        pair_sel  = {r_idx[0], 1'b0};
        pair_a    = r_word[8*pair_sel +: 8];
        pair_b    = r_word[8*(pair_sel + 2'd1) +: 8];
        pair_half = ({1'b0, r_idx[0], 1'b1} >= r_nbytes);
        nib_byte  = r_word[8*r_idx +: 8];
        pix_a     = '0;
        pix_b     = '0;
        unique case (r_format)
            pw565_pkg::FMT_SWAP16: begin
                n_out_word = {r_word[15:0], r_word[31:16]};
                n_out_send = r_nbytes;
            end
            pw565_pkg::FMT_RGB332,
            pw565_pkg::FMT_GRAY8: begin
                if (r_format == pw565_pkg::FMT_RGB332) begin
                    pix_a = pw565_pkg::rgb332_to_565(pair_a);
                    pix_b = pw565_pkg::rgb332_to_565(pair_b);
                end else begin
                    pix_a = pw565_pkg::gray8_to_565(pair_a);
                    pix_b = pw565_pkg::gray8_to_565(pair_b);
                end
                // odd last byte fills only the upper half
                n_out_word = pair_half ? {pix_a, 16'h0000} : {pix_a, pix_b};
                n_out_send = pair_half ? 3'd2 : 3'd4;
            end
            pw565_pkg::FMT_GRAY4,
            pw565_pkg::FMT_CLUT: begin
                if (r_format == pw565_pkg::FMT_GRAY4) begin
                    pix_a = pw565_pkg::gray4_to_565(nib_byte[7:4]);
                    pix_b = pw565_pkg::gray4_to_565(nib_byte[3:0]);
                end else begin
                    pix_a = r_pal[nib_byte[7:6]][16*nib_byte[5:4] +: 16];
                    pix_b = r_pal[nib_byte[3:2]][16*nib_byte[1:0] +: 16];
                end
                n_out_word = {pix_a, pix_b};
                n_out_send = 3'd4;
            end
            default: begin
                // pass mode and unused codes
                n_out_word = r_word;
                n_out_send = r_nbytes;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= n_out_word;
            r_out_send <= n_out_send;
            r_out_last <= is_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b00000, r_out_send, r_out_word};
    assign o_m_axis_tlast  = r_out_last;

endmodule

### rtl/core/pw565_checker.sv
// ============================================================================
// pw565_checker
// Port-level checks for the RGB565 packer, bound to the top level.
// ============================================================================
module pw565_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // byte count of every output word is one to four
    a_send_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[34:32] != 3'd0 &&
                             o_m_axis_tdata[34:32] <= 3'd4))
        else $error("send byte count out of range");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[39:35] == 5'b00000))
        else $error("tdata padding not zero");

    // stalled output word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("stalled output word changed");

endmodule

bind pixel_to_rgb565_word_packer_top pw565_checker u_pw565_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

### sim/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the RGB565 word packer.
// ============================================================================
// A queue of source words feeds a clocked stream driver. Each accepted word is
// converted by a local model of the packer into the display words it should
// produce. A clocked monitor compares every output word, field by field, with
// the oldest of those. Format and colour table writes happen only while the
// block is drained. Both sides idle in short random bursts, the receiver also
// holds off for long stretches, and the last phase runs without idling.
// ============================================================================
module testbench;

    // format codes the block does not define; they must act as pass mode
    localparam logic [2:0] FMT_UNUSED_A = 3'd6;
    localparam logic [2:0] FMT_UNUSED_B = 3'd7;

    localparam int MAX_CYCLES  = 200000;
    localparam int IDLE_GUARD  = 6;
    localparam int LONG_HOLD   = 48;
    localparam int RAND_PHASES = 9;
    localparam int PHASE_WORDS = 22;

    typedef struct packed {
        logic [31:0] source_word;
        logic [2:0]  valid_bytes;
    } t_source_item;

    typedef struct packed {
        logic [31:0] packed_word;
        logic [2:0]  send_bytes;
        logic        run_end;
    } t_display_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;   // [31:0] source_word, [34:32] valid_bytes
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // [31:0] packed_word, [34:32] send_bytes
    logic        o_m_axis_tlast;        // run_end
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    // local copy of the block's registers
    logic [2:0]  format_shadow = pw565_pkg::FMT_PASS;
    logic [63:0] colour_table [4] = '{default: '0};

    t_source_item  source_words_pending [$];
    t_display_word awaited_words [$];
    int source_words_issued = 0;
    int source_words_accepted = 0;
    int hold_requests = 0;
    int error_count = 0;
    int cycle_count = 0;
    bit quiet_tail = 1'b0;

    pixel_to_rgb565_word_packer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Pixel conversions
    // ------------------------------------------------------------------------
    function automatic logic [15:0] widen_rgb332(input logic [7:0] v);
        logic [15:0] red, grn, blu;
        red = (v >> 5) & 16'h7;
        grn = (v >> 2) & 16'h7;
        blu = v & 16'h3;
        return (((red << 2) | (red >> 1)) << 11) | (((grn << 3) | grn) << 5)
             | ((blu << 3) | (blu << 1) | (blu >> 1));
    endfunction

    function automatic logic [15:0] widen_gray8(input logic [7:0] v);
        logic [15:0] g5, g6;
        g5 = v >> 3;
        g6 = v >> 2;
        return (g5 << 11) | (g6 << 5) | g5;
    endfunction

    function automatic logic [15:0] widen_gray4(input logic [3:0] nib);
        logic [15:0] g5, g6;
        g6 = ({12'h000, nib} << 2) & 16'h3C;
        g6 = g6 | (g6 >> 4);
        g5 = g6 >> 1;
        return (g5 << 11) | (g6 << 5) | g5;
    endfunction

    function automatic logic [15:0] lookup_colour(input logic [3:0] idx);
        logic [63:0] quarter;
        quarter = colour_table[idx[3:2]];
        return quarter[16*idx[1:0] +: 16];
    endfunction

    // Expected display words for one accepted source word
    function automatic void convert_to_display_words(input t_source_item item);
        int n;
        logic [7:0] src_byte [4];
        logic [15:0] first_px, second_px;
        t_display_word w;
        n = item.valid_bytes;
        if (n == 0)
            return;
        if (n > 4)
            n = 4;
        for (int i = 0; i < 4; i++)
            src_byte[i] = item.source_word[8*i +: 8];
        case (format_shadow)
            pw565_pkg::FMT_SWAP16: begin
                w.packed_word = {item.source_word[15:0], item.source_word[31:16]};
                w.send_bytes  = 3'(n);
                w.run_end     = 1'b1;
                awaited_words.push_back(w);
            end
            pw565_pkg::FMT_RGB332, pw565_pkg::FMT_GRAY8: begin
                // two bytes per word; an odd last byte fills the upper half only
                for (int i = 0; i < n; i += 2) begin
                    first_px = (format_shadow == pw565_pkg::FMT_RGB332)
                             ? widen_rgb332(src_byte[i]) : widen_gray8(src_byte[i]);
                    w.run_end = (i + 2 >= n);
                    if (i + 1 < n) begin
                        second_px = (format_shadow == pw565_pkg::FMT_RGB332)
                                  ? widen_rgb332(src_byte[i+1]) : widen_gray8(src_byte[i+1]);
                        w.packed_word = {first_px, second_px};
                        w.send_bytes  = 3'd4;
                    end else begin
                        w.packed_word = {first_px, 16'h0000};
                        w.send_bytes  = 3'd2;
                    end
                    awaited_words.push_back(w);
                end
            end
            pw565_pkg::FMT_GRAY4, pw565_pkg::FMT_CLUT: begin
                // one word per byte, high nibble first
                for (int i = 0; i < n; i++) begin
                    if (format_shadow == pw565_pkg::FMT_GRAY4) begin
                        first_px  = widen_gray4(src_byte[i][7:4]);
                        second_px = widen_gray4(src_byte[i][3:0]);
                    end else begin
                        first_px  = lookup_colour(src_byte[i][7:4]);
                        second_px = lookup_colour(src_byte[i][3:0]);
                    end
                    w.packed_word = {first_px, second_px};
                    w.send_bytes  = 3'd4;
                    w.run_end     = (i + 1 == n);
                    awaited_words.push_back(w);
                end
            end
            default: begin
                // pass mode and the unused codes
                w.packed_word = item.source_word;
                w.send_bytes  = 3'(n);
                w.run_end     = 1'b1;
                awaited_words.push_back(w);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Source driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : source_driver
        t_source_item current_item;
        int source_gap;
        logic offering;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            source_gap = 0;
        end else begin
            offering = i_s_axis_tvalid;
            if (offering && o_s_axis_tready) begin
                convert_to_display_words(current_item);
                source_words_accepted++;
                offering = 1'b0;
                if (!quiet_tail && $urandom_range(0, 3) == 0)
                    source_gap = $urandom_range(1, 5);
            end
            if (!offering) begin
                if (source_gap > 0) begin
                    source_gap--;
                end else if (source_words_pending.size() != 0) begin
                    current_item = source_words_pending.pop_front();
                    i_s_axis_tdata <= {5'b0, current_item.valid_bytes, current_item.source_word};
                    offering = 1'b1;
                end
            end
            i_s_axis_tvalid <= offering;
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : display_word_monitor
        t_display_word got, want;
        int sink_gap;
        int hold_left;
        int holds_served;
        logic sink_ready;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            sink_gap = 0;
            hold_left = 0;
            holds_served = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.packed_word = o_m_axis_tdata[31:0];
                got.send_bytes  = o_m_axis_tdata[34:32];
                got.run_end     = o_m_axis_tlast;
                if (awaited_words.size() == 0) begin
                    $error("unexpected word: packed_word %h send_bytes %0d run_end %0d",
                           got.packed_word, got.send_bytes, got.run_end);
                    error_count++;
                end else begin
                    want = awaited_words.pop_front();
                    if (got.packed_word !== want.packed_word) begin
                        $error("packed_word: expected %h, got %h",
                               want.packed_word, got.packed_word);
                        error_count++;
                    end
                    if (got.send_bytes !== want.send_bytes) begin
                        $error("send_bytes: expected %0d, got %0d",
                               want.send_bytes, got.send_bytes);
                        error_count++;
                    end
                    if (got.run_end !== want.run_end) begin
                        $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
                        error_count++;
                    end
                end
            end
            // a long hold-off lets the block fill up and stall its input
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                sink_ready = 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                sink_ready = 1'b0;
            end else begin
                sink_ready = 1'b1;
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                    sink_gap = $urandom_range(1, 5);
            end
            i_m_axis_tready <= sink_ready;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic void offer_word(input logic [31:0] word, input logic [2:0] count);
        t_source_item item;
        item.source_word = word;
        item.valid_bytes = count;
        source_words_pending.push_back(item);
        source_words_issued++;
    endfunction

    task automatic write_register(input logic [2:0] index, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            pw565_pkg::REG_FORMAT: format_shadow   = value[2:0];
            pw565_pkg::REG_PAL_0:  colour_table[0] = value;
            pw565_pkg::REG_PAL_1:  colour_table[1] = value;
            pw565_pkg::REG_PAL_2:  colour_table[2] = value;
            pw565_pkg::REG_PAL_3:  colour_table[3] = value;
            default: ;
        endcase
    endtask

    // every word taken and every display word seen, then a further idle guard
    task automatic wait_until_drained();
        while (source_words_accepted != source_words_issued || awaited_words.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [2:0] all_formats [8];
        logic [2:0] pal_regs [4];
        logic [2:0] count;
        logic [31:0] word;
        logic [63:0] pal_value;
        all_formats = '{pw565_pkg::FMT_PASS, pw565_pkg::FMT_SWAP16,
                        pw565_pkg::FMT_RGB332, pw565_pkg::FMT_GRAY8,
                        pw565_pkg::FMT_GRAY4, pw565_pkg::FMT_CLUT,
                        FMT_UNUSED_A, FMT_UNUSED_B};
        pal_regs = '{pw565_pkg::REG_PAL_0, pw565_pkg::REG_PAL_1,
                     pw565_pkg::REG_PAL_2, pw565_pkg::REG_PAL_3};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset format is pass: zero count and an oversized count
        offer_word($urandom, 3'd0);
        offer_word($urandom, 3'd7);
        wait_until_drained();

        // colour table at its extremes plus a spread of entries
        write_register(pw565_pkg::REG_PAL_0, 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(pw565_pkg::REG_PAL_1, 64'h0123_4567_89AB_CDEF);
        write_register(pw565_pkg::REG_PAL_2, {$urandom, $urandom});
        write_register(pw565_pkg::REG_PAL_3, 64'h0000_0000_0000_0000);

        // every defined format with full, all-zero and odd-length words; one two-byte word for the unused codes
        foreach (all_formats[f]) begin
            write_register(pw565_pkg::REG_FORMAT, {61'd0, all_formats[f]});
            if (f < 6) begin
                offer_word(32'hFFFF_FFFF, 3'd4);
                offer_word(32'h0000_0000, 3'd3);
                offer_word($urandom, 3'd1);
            end else begin
                offer_word($urandom, 3'd2);
            end
            if (all_formats[f] == pw565_pkg::FMT_GRAY4)
                offer_word($urandom, 3'd5);
            wait_until_drained();
        end

        // random phases, last one without idling
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase == RAND_PHASES - 1)
                quiet_tail = 1'b1;
            if ($urandom_range(0, 9) < 8)
                write_register(pw565_pkg::REG_FORMAT,
                               {61'd0, all_formats[$urandom_range(0, 5)]});
            else
                write_register(pw565_pkg::REG_FORMAT,
                               {61'd0, all_formats[$urandom_range(6, 7)]});
            foreach (pal_regs[r]) begin
                if ($urandom_range(0, 1) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       pal_value = '0;
                        1:       pal_value = '1;
                        default: pal_value = {$urandom, $urandom};
                    endcase
                    write_register(pal_regs[r], pal_value);
                end
            end
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if ($urandom_range(0, 19) < 17)
                    count = 3'($urandom_range(1, 4));
                else
                    count = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
                case ($urandom_range(0, 19))
                    0:       word = 32'h0000_0000;
                    1:       word = 32'hFFFF_FFFF;
                    default: word = $urandom;
                endcase
                offer_word(word, count);
            end
            if (phase == 2 || phase == 5)
                hold_requests++;
            wait_until_drained();
        end

        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pw565_pkg.sv
rtl/core/pixel_to_rgb565_word_packer_top.sv
rtl/core/pw565_checker.sv
sim/testbench.sv
